### design/quorum_lock_voter_defines.svh
// ----------------------------------------------------------------------------
// quorum lock voter assertion macros
// shared concurrent assertion forms, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef QUORUM_LOCK_VOTER_DEFINES_SVH
`define QUORUM_LOCK_VOTER_DEFINES_SVH

// same-cycle implication
`define QLV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qlv: same-cycle check failed");

// next-cycle implication
`define QLV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qlv: next-cycle check failed");

`endif

### design/qlv_pkg.sv
// ----------------------------------------------------------------------------
// qlv_pkg
// types, codes and helpers for the quorum lock voter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlv_pkg;

  localparam int ID_W    = 6;
  localparam int STAMP_W = 32;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NODE_COUNT_DEF  = 64;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOCKED   = 2'd0,
    KIND_FAILED   = 2'd1,
    KIND_INQUIRE  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef struct packed {
    logic               cmd;
    logic [ID_W-1:0]    req_id;
    logic [STAMP_W-1:0] req_stamp;
  } req_t;

  typedef struct packed {
    logic [1:0]         reply_kind;
    logic [ID_W-1:0]    dest_id;
    logic [STAMP_W-1:0] max_stamp;
  } reply_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // key a strictly ahead of key b: lower stamp, then lower id
  function automatic logic outranks(logic [STAMP_W-1:0] sa, logic [ID_W-1:0] ia,
                                    logic [STAMP_W-1:0] sb, logic [ID_W-1:0] ib);
    return (sa < sb) || ((sa == sb) && (ia < ib));
  endfunction

endpackage

### design/qlv_ram.sv
// ----------------------------------------------------------------------------
// qlv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlv_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/quorum_lock_voter.sv
// ----------------------------------------------------------------------------
// quorum_lock_voter
// voter side of quorum mutual exclusion: one vote, a wait queue kept in
// arrival order and granted by (stamp, id), locked / failed / inquire / overflow replies
// ----------------------------------------------------------------------------
// usage:
//   a beat is taken on req_i when start is high and busy is low. busy
//   stays high until the beat is finished. each beat gives zero or one reply,
//   shown on reply_o for exactly one cycle with reply_valid_o high, in the
//   cycle busy falls. the receiver cannot stall the reply.
// steps: an id at or above NODE_COUNT is first reduced by NODE_COUNT until
// below it (never when NODE_COUNT is at least 64). a request to a free
// voter, a dropped request and a release with an empty queue end there; a
// queued request scans every queued entry, then appends; a release finds
// the earliest entry, then shifts the entries behind it down one place.
// the queue ram is read one entry per cycle; the scan and the compaction
// that comes before a grant go through that single read port, and one key
// comparator serves every key comparison.
// reset: voter free, queue empty, highest stamp 1; queue contents are not
// cleared, only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quorum_lock_voter_defines.svh"

module quorum_lock_voter #(
  parameter int QUEUE_DEPTH = qlv_pkg::QUEUE_DEPTH_DEF,
  parameter int NODE_COUNT  = qlv_pkg::NODE_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  qlv_pkg::req_t   req_i,
  output logic            busy,
  output logic            reply_valid_o,
  output qlv_pkg::reply_t reply_o
);

  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NCW = $clog2(NODE_COUNT + 1);
  localparam int NW  = (qlv_pkg::ID_W > NCW) ? qlv_pkg::ID_W : NCW;
  localparam int EW  = $bits(qlv_pkg::entry_t);

  localparam logic [NW-1:0] NODE_LIM = NW'(NODE_COUNT);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic                        cmd_q, cmd_d;
  logic [qlv_pkg::ID_W-1:0]    id_q, id_d;
  logic [qlv_pkg::STAMP_W-1:0] stamp_q, stamp_d;

  logic                        locked_q, locked_d;
  logic [qlv_pkg::ID_W-1:0]    holder_id_q, holder_id_d;
  logic [qlv_pkg::STAMP_W-1:0] holder_stamp_q, holder_stamp_d;
  logic                        inq_q, inq_d;
  logic [qlv_pkg::STAMP_W-1:0] highest_q, highest_d;
  logic [CW-1:0]               count_q, count_d;

  logic [IW-1:0]               idx_q, idx_d;
  logic                        beaten_q, beaten_d;
  logic [IW-1:0]               best_idx_q, best_idx_d;
  logic [qlv_pkg::ID_W-1:0]    best_id_q, best_id_d;
  logic [qlv_pkg::STAMP_W-1:0] best_stamp_q, best_stamp_d;

  qlv_pkg::reply_t reply_q, reply_d;
  logic            reply_valid_q, reply_valid_d;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [EW-1:0]               ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [EW-1:0]               ram_rdata;
  qlv_pkg::entry_t             rd_entry;

  logic [qlv_pkg::STAMP_W-1:0] cmp_a_stamp;
  logic [qlv_pkg::ID_W-1:0]    cmp_a_id;
  logic [qlv_pkg::STAMP_W-1:0] cmp_b_stamp;
  logic [qlv_pkg::ID_W-1:0]    cmp_b_id;
  logic                        cmp_ahead;

  logic                        scan_last;
  logic                        take;
  logic [IW-1:0]               sel_idx;
  logic [qlv_pkg::ID_W-1:0]    sel_id;
  logic [qlv_pkg::STAMP_W-1:0] sel_stamp;
  logic                        emit_en;
  qlv_pkg::kind_e              emit_kind;
  logic [qlv_pkg::ID_W-1:0]    emit_dest;
  logic                        grant_en;
  logic [qlv_pkg::ID_W-1:0]    grant_id;
  logic [qlv_pkg::STAMP_W-1:0] grant_stamp;

  assign rd_entry  = qlv_pkg::entry_t'(ram_rdata);
  assign scan_last = (CW'(idx_q) == (count_q - CW'(1)));

  qlv_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared key comparator operands
  always_comb begin
    cmp_a_stamp = rd_entry.stamp;
    cmp_a_id    = rd_entry.id;
    cmp_b_stamp = stamp_q;
    cmp_b_id    = id_q;
    unique case (state_q)
      S_MOD: begin
        cmp_a_stamp = holder_stamp_q;
        cmp_a_id    = holder_id_q;
      end
      S_FIND: begin
        cmp_b_stamp = best_stamp_q;
        cmp_b_id    = best_id_q;
      end
      default: begin
      end
    endcase
  end

  assign cmp_ahead = qlv_pkg::outranks(cmp_a_stamp, cmp_a_id, cmp_b_stamp, cmp_b_id);

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    id_d           = id_q;
    stamp_d        = stamp_q;
    locked_d       = locked_q;
    holder_id_d    = holder_id_q;
    holder_stamp_d = holder_stamp_q;
    inq_d          = inq_q;
    highest_d      = highest_q;
    count_d        = count_q;
    idx_d          = idx_q;
    beaten_d       = beaten_q;
    best_idx_d     = best_idx_q;
    best_id_d      = best_id_q;
    best_stamp_d   = best_stamp_q;
    reply_d        = reply_q;
    reply_valid_d  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    take           = 1'b0;
    sel_idx        = best_idx_q;
    sel_id         = best_id_q;
    sel_stamp      = best_stamp_q;
    emit_en        = 1'b0;
    emit_kind      = qlv_pkg::KIND_LOCKED;
    emit_dest      = '0;
    grant_en       = 1'b0;
    grant_id       = best_id_q;
    grant_stamp    = best_stamp_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = req_i.cmd;
          id_d    = req_i.req_id;
          stamp_d = req_i.req_stamp;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (NW'(id_q) >= NODE_LIM) begin
          id_d = qlv_pkg::ID_W'(NW'(id_q) - NODE_LIM);
        end else if (cmd_q == qlv_pkg::CMD_REQUEST) begin
          highest_d = (stamp_q > highest_q) ? stamp_q : highest_q;
          if (!locked_q) begin
            locked_d       = 1'b1;
            holder_id_d    = id_q;
            holder_stamp_d = stamp_q;
            inq_d          = 1'b0;
            emit_en        = 1'b1;
            emit_kind      = qlv_pkg::KIND_LOCKED;
            emit_dest      = id_q;
            state_d        = S_IDLE;
          end else if (count_q == FULL_CNT) begin
            emit_en   = 1'b1;
            emit_kind = qlv_pkg::KIND_OVERFLOW;
            emit_dest = id_q;
            state_d   = S_IDLE;
          end else begin
            beaten_d  = cmp_ahead;
            idx_d     = '0;
            ram_raddr = '0;
            state_d   = (count_q == '0) ? S_APPEND : S_SCAN;
          end
        end else begin
          if (!locked_q) begin
            state_d = S_IDLE;
          end else if (count_q == '0) begin
            locked_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            idx_d     = '0;
            ram_raddr = '0;
            state_d   = S_FIND;
          end
        end
      end
      S_SCAN: begin
        if (cmp_ahead) begin
          beaten_d = 1'b1;
        end
        if (scan_last) begin
          state_d = S_APPEND;
        end else begin
          idx_d     = idx_q + IW'(1);
          ram_raddr = idx_q + IW'(1);
        end
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IW-1:0];
        ram_wdata = {id_q, stamp_q};
        count_d   = count_q + CW'(1);
        state_d   = S_IDLE;
        if (beaten_q) begin
          emit_en   = 1'b1;
          emit_kind = qlv_pkg::KIND_FAILED;
          emit_dest = id_q;
        end else if (!inq_q) begin
          inq_d     = 1'b1;
          emit_en   = 1'b1;
          emit_kind = qlv_pkg::KIND_INQUIRE;
          emit_dest = holder_id_q;
        end
      end
      S_FIND: begin
        take = (idx_q == '0) || cmp_ahead;
        if (take) begin
          sel_idx   = idx_q;
          sel_id    = rd_entry.id;
          sel_stamp = rd_entry.stamp;
        end
        best_idx_d   = sel_idx;
        best_id_d    = sel_id;
        best_stamp_d = sel_stamp;
        if (scan_last) begin
          if (CW'(sel_idx) == (count_q - CW'(1))) begin
            grant_en    = 1'b1;
            grant_id    = sel_id;
            grant_stamp = sel_stamp;
          end else begin
            idx_d     = sel_idx + IW'(1);
            ram_raddr = sel_idx + IW'(1);
            state_d   = S_SHIFT;
          end
        end else begin
          idx_d     = idx_q + IW'(1);
          ram_raddr = idx_q + IW'(1);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - IW'(1);
        ram_wdata = ram_rdata;
        if (scan_last) begin
          grant_en = 1'b1;
        end else begin
          idx_d     = idx_q + IW'(1);
          ram_raddr = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (grant_en) begin
      holder_id_d    = grant_id;
      holder_stamp_d = grant_stamp;
      count_d        = count_q - CW'(1);
      inq_d          = 1'b0;
      emit_en        = 1'b1;
      emit_kind      = qlv_pkg::KIND_LOCKED;
      emit_dest      = grant_id;
      state_d        = S_IDLE;
    end

    if (emit_en) begin
      reply_d.reply_kind = emit_kind;
      reply_d.dest_id    = emit_dest;
      reply_d.max_stamp  = highest_d;
      reply_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      locked_q       <= 1'b0;
      holder_id_q    <= '0;
      holder_stamp_q <= '0;
      inq_q          <= 1'b0;
      highest_q      <= qlv_pkg::STAMP_W'(1);
      count_q        <= '0;
      reply_valid_q  <= 1'b0;
    end else begin
      state_q        <= state_d;
      locked_q       <= locked_d;
      holder_id_q    <= holder_id_d;
      holder_stamp_q <= holder_stamp_d;
      inq_q          <= inq_d;
      highest_q      <= highest_d;
      count_q        <= count_d;
      reply_valid_q  <= reply_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    stamp_q      <= stamp_d;
    idx_q        <= idx_d;
    beaten_q     <= beaten_d;
    best_idx_q   <= best_idx_d;
    best_id_q    <= best_id_d;
    best_stamp_q <= best_stamp_d;
    reply_q      <= reply_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign reply_valid_o = reply_valid_q;
  assign reply_o       = reply_q;

  `QLV_ASSERT_IMP(a_reply_when_idle, clk_i, rst_ni, reply_valid_q, state_q == S_IDLE)
  `QLV_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT)
  `QLV_ASSERT_IMP(a_queue_needs_lock, clk_i, rst_ni, count_q != '0, locked_q)
  `QLV_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

endmodule

### tb/tb_quorum_lock_voter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quorum_lock_voter
// self-checking bench for the quorum lock voter: a mirror of the vote, the
// holder and the wait queue predicts every reply; directed beats cover grant
// order, ties, inquire, idle releases and queue overflow, then bursty random
// traffic drives the queue between empty and full
// ----------------------------------------------------------------------------
module tb_quorum_lock_voter;

  localparam int QDEPTH       = qlv_pkg::QUEUE_DEPTH_DEF;
  localparam int NODES        = qlv_pkg::NODE_COUNT_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BEATS = 1800;

  localparam int ID_W    = qlv_pkg::ID_W;
  localparam int STAMP_W = qlv_pkg::STAMP_W;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  qlv_pkg::req_t   req_i;
  logic            busy;
  logic            reply_valid_o;
  qlv_pkg::reply_t reply_o;

  quorum_lock_voter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_i         (req_i),
    .busy          (busy),
    .reply_valid_o (reply_valid_o),
    .reply_o       (reply_o)
  );

  // mirror of the voter
  logic               voter_locked;
  logic [ID_W-1:0]    holder_id;
  logic [STAMP_W-1:0] holder_stamp;
  logic               inquire_out;
  logic [STAMP_W-1:0] top_stamp;
  qlv_pkg::entry_t    waiters[$];

  qlv_pkg::reply_t    pending_replies[$];
  int unsigned        mismatches;
  int unsigned        idle_cycles;
  int unsigned        burst_left;
  logic [STAMP_W-1:0] stamp_clock;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic key_ahead(logic [STAMP_W-1:0] sa, logic [ID_W-1:0] ia,
                                     logic [STAMP_W-1:0] sb, logic [ID_W-1:0] ib);
    if (sa < sb) return 1'b1;
    return (sa == sb) && (ia < ib);
  endfunction

  function automatic void post_reply(qlv_pkg::kind_e kind, logic [ID_W-1:0] dest);
    qlv_pkg::reply_t r;
    r.reply_kind = kind;
    r.dest_id    = dest;
    r.max_stamp  = top_stamp;
    pending_replies.push_back(r);
  endfunction

  function automatic void apply_vote(qlv_pkg::req_t b);
    logic [ID_W-1:0] id;
    logic            beaten;
    int              best;
    qlv_pkg::entry_t e;
    id = ID_W'(b.req_id % NODES);
    if (b.cmd == qlv_pkg::CMD_REQUEST) begin
      if (b.req_stamp > top_stamp) top_stamp = b.req_stamp;
      if (!voter_locked) begin
        voter_locked = 1'b1;
        holder_id    = id;
        holder_stamp = b.req_stamp;
        inquire_out  = 1'b0;
        post_reply(qlv_pkg::KIND_LOCKED, id);
      end else if (waiters.size() >= QDEPTH) begin
        post_reply(qlv_pkg::KIND_OVERFLOW, id);
      end else begin
        beaten = key_ahead(holder_stamp, holder_id, b.req_stamp, id);
        foreach (waiters[i])
          if (key_ahead(waiters[i].stamp, waiters[i].id, b.req_stamp, id)) beaten = 1'b1;
        e.id    = id;
        e.stamp = b.req_stamp;
        waiters.push_back(e);
        if (beaten) begin
          post_reply(qlv_pkg::KIND_FAILED, id);
        end else if (!inquire_out) begin
          inquire_out = 1'b1;
          post_reply(qlv_pkg::KIND_INQUIRE, holder_id);
        end
      end
    end else if (voter_locked) begin
      if (waiters.size() == 0) begin
        voter_locked = 1'b0;
      end else begin
        best = 0;
        for (int i = 1; i < waiters.size(); i++)
          if (key_ahead(waiters[i].stamp, waiters[i].id, waiters[best].stamp, waiters[best].id))
            best = i;
        holder_id    = waiters[best].id;
        holder_stamp = waiters[best].stamp;
        waiters.delete(best);
        inquire_out  = 1'b0;
        post_reply(qlv_pkg::KIND_LOCKED, holder_id);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // one beat: hold start until the voter takes it, then update the mirror
  task automatic send_beat(logic cmd, logic [ID_W-1:0] id, logic [STAMP_W-1:0] stamp);
    qlv_pkg::req_t b;
    b.cmd       = cmd;
    b.req_id    = id;
    b.req_stamp = stamp;
    start <= 1'b1;
    req_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_vote(b);
  endtask

  // bursts of beats separated by random gaps
  task automatic pace();
    int unsigned gap;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic test_idle_release();
    send_beat(qlv_pkg::CMD_RELEASE, '1, '1);
    pace();
  endtask

  task automatic test_grant_order();
    send_beat(qlv_pkg::CMD_REQUEST, 6'd5, 32'd0);
    send_beat(qlv_pkg::CMD_REQUEST, 6'd63, 32'h8000_0000);
    send_beat(qlv_pkg::CMD_REQUEST, 6'd4, 32'd0);
    pace();
    // inquire already out, then an equal key
    send_beat(qlv_pkg::CMD_REQUEST, 6'd3, 32'd0);
    send_beat(qlv_pkg::CMD_REQUEST, 6'd3, 32'd0);
    pace();
    repeat (4) begin
      send_beat(qlv_pkg::CMD_RELEASE, ID_W'($urandom), $urandom);
      pace();
    end
    // empty queue frees the voter, then a release to a free voter
    send_beat(qlv_pkg::CMD_RELEASE, '0, '0);
    send_beat(qlv_pkg::CMD_RELEASE, '1, '1);
    pace();
  endtask

  task automatic test_queue_overflow();
    send_beat(qlv_pkg::CMD_REQUEST, 6'd10, 32'd100);
    for (int i = 0; i < QDEPTH; i++) begin
      send_beat(qlv_pkg::CMD_REQUEST, ID_W'(11 + i), STAMP_W'(200 + i));
      pace();
    end
    send_beat(qlv_pkg::CMD_REQUEST, 6'd63, 32'hFFFF_FFFF);
    pace();
  endtask

  task automatic test_random_traffic();
    int unsigned        release_pct;
    int unsigned        pick;
    logic [STAMP_W-1:0] stamp;
    release_pct = 30;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 150 == 0) begin
        release_pct = $urandom_range(15, 60);
        stamp_clock = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
      end
      if (n == RANDOM_BEATS / 2) drain_replies();
      if ($urandom_range(99) < release_pct) begin
        send_beat(qlv_pkg::CMD_RELEASE, ID_W'($urandom), $urandom);
      end else begin
        pick = $urandom_range(99);
        stamp_clock += $urandom_range(0, 2);
        if (pick < 65) stamp = stamp_clock + $urandom_range(0, 3);
        else if (pick < 80) stamp = $urandom;
        else if (pick < 85) stamp = '0;
        else if (pick < 90) stamp = '1;
        else stamp = holder_stamp;
        send_beat(qlv_pkg::CMD_REQUEST, ID_W'($urandom), stamp);
      end
      pace();
    end
  endtask

  // reply checker
  always @(posedge clk_i) begin
    qlv_pkg::reply_t want;
    if (rst_ni === 1'b1 && reply_valid_o !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", 32'(reply_o.reply_kind), 32'(reply_o.dest_id));
      end else begin
        want = pending_replies.pop_front();
        if (reply_o.reply_kind !== want.reply_kind)
          report_mismatch("reply_kind", 32'(reply_o.reply_kind), 32'(want.reply_kind));
        if (reply_o.dest_id !== want.dest_id)
          report_mismatch("dest_id", 32'(reply_o.dest_id), 32'(want.dest_id));
        if (reply_o.max_stamp !== want.max_stamp)
          report_mismatch("max_stamp", reply_o.max_stamp, want.max_stamp);
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start && busy === 1'b0) || reply_valid_o === 1'b1) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    burst_left   = 1;
    stamp_clock  = '0;
    voter_locked = 1'b0;
    holder_id    = '0;
    holder_stamp = '0;
    inquire_out  = 1'b0;
    top_stamp    = 32'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_release();
    test_grant_order();
    drain_replies();
    test_queue_overflow();
    test_random_traffic();

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
